[design/cls_pkg.sv]
// Package for the command list sequencer.
// Holds the shared constants, field codes and structs. It depends on nothing.
package cls_pkg;

  localparam int DEF_ADDR_BITS = 19;
  localparam int LIMIT_W       = 12;
  localparam int WORD_W        = 16;
  localparam int TYPE_W        = 4;
  localparam int OP_W          = 16;
  localparam int STATUS_W      = 2;
  localparam int ALIGN_BITS    = 3;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2000;
  localparam logic [TYPE_W-1:0]  MAX_TYPE    = 4'd11;
  localparam int                 STEP_BYTES  = 32;

  localparam int END_BIT   = 15;
  localparam int SKIP_BIT  = 14;
  localparam int JUMP_HI   = 13;
  localparam int JUMP_LO   = 12;
  localparam int TYPE_HI   = 3;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  typedef enum logic [1:0] {
    JUMP_NEXT   = 2'd0,
    JUMP_ASSIGN = 2'd1,
    JUMP_CALL   = 2'd2,
    JUMP_RETURN = 2'd3
  } jump_t;

  typedef struct packed {
    logic execute;
    logic finished;
    logic aborted;
    logic draw_end;
  } cls_flags_t;

  typedef struct packed {
    logic                ret_valid;
    logic [LIMIT_W-1:0]  count;
    logic [STATUS_W-1:0] status;
    logic                walking;
  } cls_ctl_t;

endpackage

[design/cls_if.sv]
// Handshake channels of the command list sequencer: command requests in, results out.
// Depends on cls_pkg for the field widths.
interface cls_in_if;
  import cls_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [WORD_W-1:0] control_word;
  logic [WORD_W-1:0] link_word;

  modport source (output valid, output kind, output control_word, output link_word,
                  input ready);
  modport sink   (input valid, input kind, input control_word, input link_word,
                  output ready);
endinterface

interface cls_out_if #(
  parameter int ADDR_BITS = cls_pkg::DEF_ADDR_BITS
);
  import cls_pkg::*;

  logic                valid;
  logic                ready;
  logic [ADDR_BITS-1:0] cmd_addr;
  logic [TYPE_W-1:0]   cmd_type;
  logic                execute;
  logic [ADDR_BITS-1:0] next_addr;
  logic                finished;
  logic                aborted;
  logic                draw_end;
  logic [STATUS_W-1:0] end_status;
  logic [OP_W-1:0]     current_op;

  modport source (output valid, output cmd_addr, output cmd_type, output execute,
                  output next_addr, output finished, output aborted, output draw_end,
                  output end_status, output current_op, input ready);
  modport sink   (input valid, input cmd_addr, input cmd_type, input execute,
                  input next_addr, input finished, input aborted, input draw_end,
                  input end_status, input current_op, output ready);
endinterface

[design/cls_step.sv]
// Decision logic for one request: start, finish, dispatch or abort, and the next address.
// Depends on cls_pkg; purely combinational.
module cls_step #(
  parameter int ADDR_BITS = cls_pkg::DEF_ADDR_BITS
) (
  input  logic                          kind,
  input  logic [cls_pkg::WORD_W-1:0]    control_word,
  input  logic [cls_pkg::WORD_W-1:0]    link_word,
  input  logic [cls_pkg::LIMIT_W-1:0]   limit,
  input  logic [ADDR_BITS-1:0]          walk_addr,
  input  logic [ADDR_BITS-1:0]          ret_addr,
  input  cls_pkg::cls_ctl_t             ctl,
  output logic [ADDR_BITS-1:0]          walk_addr_nxt,
  output logic [ADDR_BITS-1:0]          ret_addr_nxt,
  output cls_pkg::cls_ctl_t             ctl_nxt,
  output logic [ADDR_BITS-1:0]          cmd_addr,
  output logic [cls_pkg::TYPE_W-1:0]    cmd_type,
  output logic [ADDR_BITS-1:0]          next_addr,
  output cls_pkg::cls_flags_t           flags
);
  import cls_pkg::*;

  logic [TYPE_W-1:0]    ty;
  logic [ADDR_BITS-1:0] seq_addr;
  logic [ADDR_BITS-1:0] link_addr;
  jump_t                jump;

  assign ty        = control_word[TYPE_HI:0];
  assign seq_addr  = walk_addr + ADDR_BITS'(STEP_BYTES);
  assign link_addr = ADDR_BITS'({{ADDR_BITS{1'b0}}, link_word, {ALIGN_BITS{1'b0}}});
  assign jump      = jump_t'(control_word[JUMP_HI:JUMP_LO]);

  always_comb begin
    walk_addr_nxt = walk_addr;
    ret_addr_nxt  = ret_addr;
    ctl_nxt       = ctl;
    cmd_addr      = walk_addr;
    cmd_type      = ty;
    next_addr     = walk_addr;
    flags         = '0;
    if (kind == KIND_START) begin
      walk_addr_nxt     = '0;
      ret_addr_nxt      = '0;
      ctl_nxt.ret_valid = 1'b0;
      ctl_nxt.count     = '0;
      ctl_nxt.status    = {1'b0, ctl.status[1]};
      ctl_nxt.walking   = 1'b1;
      cmd_addr          = '0;
      cmd_type          = '0;
      next_addr         = '0;
    end else if (!ctl.walking) begin
      flags.finished = 1'b1;
    end else if (control_word[END_BIT] || ctl.count >= limit) begin
      ctl_nxt.status[1] = 1'b1;
      ctl_nxt.walking   = 1'b0;
      flags.finished    = 1'b1;
      flags.draw_end    = 1'b1;
    end else if (!control_word[SKIP_BIT] && ty > MAX_TYPE) begin
      ctl_nxt.status[1] = 1'b1;
      ctl_nxt.walking   = 1'b0;
      flags.finished    = 1'b1;
      flags.aborted     = 1'b1;
    end else begin
      flags.execute = !control_word[SKIP_BIT];
      unique case (jump)
        JUMP_NEXT:   next_addr = seq_addr;
        JUMP_ASSIGN: next_addr = link_addr;
        JUMP_CALL: begin
          next_addr = link_addr;
          if (!ctl.ret_valid) begin
            ret_addr_nxt      = seq_addr;
            ctl_nxt.ret_valid = 1'b1;
          end
        end
        JUMP_RETURN: begin
          if (ctl.ret_valid) begin
            next_addr         = ret_addr;
            ctl_nxt.ret_valid = 1'b0;
          end else begin
            next_addr = seq_addr;
          end
        end
        default: next_addr = seq_addr;
      endcase
      walk_addr_nxt = next_addr;
      ctl_nxt.count = ctl.count + LIMIT_W'(1);
    end
  end

endmodule

[design/command_list_sequencer.sv]
// Top level of the command list sequencer: request register, decision logic, result register.
// Depends on cls_pkg, cls_if and cls_step.
//
// The sequencer takes one request per clock cycle: the request register feeds the decision
// logic and the walk state update, and the outcome is captured in the result register. Each
// request's decision is a single pass of compares and an address select, so back-to-back
// requests run at full rate; a stalled result holds the request register, and the input
// stalls once both are full. The command limit is written through cfg_we and cfg_data; the
// user must write it only while no request is outstanding, which the block does not enforce.
module command_list_sequencer #(
  parameter int ADDR_BITS = cls_pkg::DEF_ADDR_BITS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  cls_in_if.sink                      in_chan,
  cls_out_if.source                   out_chan,
  input  logic                        cfg_we,
  input  logic [cls_pkg::LIMIT_W-1:0] cfg_data
);
  import cls_pkg::*;

  logic                 in_valid_r;
  logic                 kind_r;
  logic [WORD_W-1:0]    ctrl_r;
  logic [WORD_W-1:0]    link_r;
  logic [LIMIT_W-1:0]   limit_r;
  logic [ADDR_BITS-1:0] walk_r;
  logic [ADDR_BITS-1:0] walk_nxt;
  logic [ADDR_BITS-1:0] ret_r;
  logic [ADDR_BITS-1:0] ret_nxt;
  cls_ctl_t             ctl_r;
  cls_ctl_t             ctl_nxt;
  logic [ADDR_BITS-1:0] cmd_addr;
  logic [TYPE_W-1:0]    cmd_type;
  logic [ADDR_BITS-1:0] next_addr;
  cls_flags_t           flags;
  logic                 out_valid_r;
  logic                 advance;

  assign advance       = in_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || advance;

  cls_step #(.ADDR_BITS(ADDR_BITS)) u_step (
    .kind          (kind_r),
    .control_word  (ctrl_r),
    .link_word     (link_r),
    .limit         (limit_r),
    .walk_addr     (walk_r),
    .ret_addr      (ret_r),
    .ctl           (ctl_r),
    .walk_addr_nxt (walk_nxt),
    .ret_addr_nxt  (ret_nxt),
    .ctl_nxt       (ctl_nxt),
    .cmd_addr      (cmd_addr),
    .cmd_type      (cmd_type),
    .next_addr     (next_addr),
    .flags         (flags)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      limit_r     <= LIMIT_RESET;
      walk_r      <= '0;
      ret_r       <= '0;
      ctl_r       <= '0;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_data;
      end
      if (in_chan.ready) begin
        in_valid_r <= in_chan.valid;
      end
      if (advance) begin
        walk_r      <= walk_nxt;
        ret_r       <= ret_nxt;
        ctl_r       <= ctl_nxt;
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      kind_r <= in_chan.kind;
      ctrl_r <= in_chan.control_word;
      link_r <= in_chan.link_word;
    end
    if (advance) begin
      out_chan.cmd_addr   <= cmd_addr;
      out_chan.cmd_type   <= cmd_type;
      out_chan.execute    <= flags.execute;
      out_chan.next_addr  <= next_addr;
      out_chan.finished   <= flags.finished;
      out_chan.aborted    <= flags.aborted;
      out_chan.draw_end   <= flags.draw_end;
      out_chan.end_status <= ctl_nxt.status;
      out_chan.current_op <= OP_W'(cmd_addr >> ALIGN_BITS);
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule

[design/cls_checker.sv]
// Port-level checks on the command list sequencer's result channel, with the bind that
// attaches them to the top level. Depends on cls_pkg.
module cls_checker #(
  parameter int ADDR_BITS = cls_pkg::DEF_ADDR_BITS
) (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [ADDR_BITS-1:0]        out_cmd_addr,
  input logic [cls_pkg::TYPE_W-1:0]  out_cmd_type,
  input logic                        out_execute,
  input logic [ADDR_BITS-1:0]        out_next_addr,
  input logic                        out_finished,
  input logic                        out_aborted,
  input logic                        out_draw_end
);
  import cls_pkg::*;

  // A stalled result must hold its addresses.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_cmd_addr) && $stable(out_next_addr))
    else $error("stalled result changed");

  // A request that ends the walk leaves the address where it was.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_finished |-> out_next_addr == out_cmd_addr && !out_execute)
    else $error("finishing request moved the walk or dispatched");

  // Abort and draw-end are exclusive and both end the walk.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_aborted || out_draw_end) |-> out_finished && !(out_aborted && out_draw_end))
    else $error("inconsistent end flags");

  // Only valid command types are dispatched.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_execute |-> out_cmd_type <= MAX_TYPE)
    else $error("invalid command type dispatched");

endmodule

bind command_list_sequencer cls_checker #(.ADDR_BITS(ADDR_BITS)) u_cls_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_chan.valid),
  .out_ready     (out_chan.ready),
  .out_cmd_addr  (out_chan.cmd_addr),
  .out_cmd_type  (out_chan.cmd_type),
  .out_execute   (out_chan.execute),
  .out_next_addr (out_chan.next_addr),
  .out_finished  (out_chan.finished),
  .out_aborted   (out_chan.aborted),
  .out_draw_end  (out_chan.draw_end)
);

[bench/tb_command_list_sequencer.sv]
// Testbench for the command list sequencer: directed and random command lists, with stalls.
// Predicts each result from its own model of the walk state and checks every result field.
// Depends on cls_pkg, cls_if and the command_list_sequencer RTL.
module tb_command_list_sequencer;
  import cls_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int ABITS        = DEF_ADDR_BITS;
  localparam int STIM_TARGET  = 1850;
  localparam int DRAIN_CYCLES = 8;
  localparam int TIMEOUT_NS   = 3_600_000;
  localparam int CALM_LO      = 700;
  localparam int CALM_HI      = 1000;

  typedef enum logic [1:0] {
    REQ_CMD,
    REQ_LIMIT,
    REQ_HOLD
  } req_op_t;

  typedef struct packed {
    req_op_t            op;
    logic               kind;
    logic [WORD_W-1:0]  ctrl;
    logic [WORD_W-1:0]  link;
    logic [LIMIT_W-1:0] limit;
  } req_t;

  typedef struct packed {
    logic [ABITS-1:0]    cmd_addr;
    logic [TYPE_W-1:0]   cmd_type;
    logic                execute;
    logic [ABITS-1:0]    next_addr;
    logic                finished;
    logic                aborted;
    logic                draw_end;
    logic [STATUS_W-1:0] end_status;
    logic [OP_W-1:0]     current_op;
  } walk_res_t;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_data;

  cls_in_if                         in_chan();
  cls_out_if #(.ADDR_BITS(ABITS))   out_chan();

  command_list_sequencer #(.ADDR_BITS(ABITS)) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  req_t      pending_q[$];
  walk_res_t walk_q[$];
  req_t      cur_req;
  int        reqs_sent;
  int        results_seen;
  int        mismatches;
  int        stim_count;

  logic [LIMIT_W-1:0]  m_limit;
  logic [ABITS-1:0]    m_addr;
  logic [ABITS-1:0]    m_ret;
  logic                m_ret_ok;
  logic [LIMIT_W-1:0]  m_count;
  logic [STATUS_W-1:0] m_status;
  logic                m_walking;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic walk_res_t predict_walk(input req_t r);
    walk_res_t         res;
    logic [ABITS-1:0]  here;
    logic [ABITS-1:0]  target;
    logic [TYPE_W-1:0] ty;
    res    = '0;
    here   = m_addr;
    target = ABITS'(32'(r.link) << ALIGN_BITS);
    ty     = r.ctrl[TYPE_HI:0];
    if (r.kind == KIND_START) begin
      m_addr         = '0;
      m_ret          = '0;
      m_ret_ok       = 1'b0;
      m_count        = '0;
      m_status       = m_status >> 1;
      m_walking      = 1'b1;
      res.end_status = m_status;
      return res;
    end
    res.cmd_addr   = here;
    res.cmd_type   = ty;
    res.current_op = OP_W'(here >> ALIGN_BITS);
    res.next_addr  = here;
    if (!m_walking) begin
      res.finished   = 1'b1;
      res.end_status = m_status;
      return res;
    end
    if (r.ctrl[END_BIT] || m_count >= m_limit) begin
      m_status[1]    = 1'b1;
      m_walking      = 1'b0;
      res.finished   = 1'b1;
      res.draw_end   = 1'b1;
      res.end_status = m_status;
      return res;
    end
    if (!r.ctrl[SKIP_BIT]) begin
      if (ty > MAX_TYPE) begin
        m_status[1]    = 1'b1;
        m_walking      = 1'b0;
        res.finished   = 1'b1;
        res.aborted    = 1'b1;
        res.end_status = m_status;
        return res;
      end
      res.execute = 1'b1;
    end
    case (jump_t'(r.ctrl[JUMP_HI:JUMP_LO]))
      JUMP_NEXT: res.next_addr = here + ABITS'(STEP_BYTES);
      JUMP_ASSIGN: res.next_addr = target;
      JUMP_CALL: begin
        if (!m_ret_ok) begin
          m_ret    = here + ABITS'(STEP_BYTES);
          m_ret_ok = 1'b1;
        end
        res.next_addr = target;
      end
      default: begin
        if (m_ret_ok) begin
          res.next_addr = m_ret;
          m_ret_ok      = 1'b0;
        end else begin
          res.next_addr = here + ABITS'(STEP_BYTES);
        end
      end
    endcase
    m_addr         = res.next_addr;
    m_count        = m_count + 1'b1;
    res.end_status = m_status;
    return res;
  endfunction

  always @(posedge clk) begin : drive_p
    req_t nxt;
    logic nv;
    logic nwe;
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
      cfg_we        <= 1'b0;
    end else begin
      nv  = in_chan.valid;
      nwe = 1'b0;
      if (in_chan.valid && in_chan.ready) begin
        walk_q.push_back(predict_walk(cur_req));
        reqs_sent++;
        nv = 1'b0;
      end
      if (!nv && pending_q.size() > 0) begin
        nxt = pending_q[0];
        case (nxt.op)
          REQ_CMD: begin
            if ((reqs_sent >= CALM_LO && reqs_sent < CALM_HI) || $urandom_range(99) >= 24) begin
              void'(pending_q.pop_front());
              cur_req              = nxt;
              nv                   = 1'b1;
              in_chan.kind         <= nxt.kind;
              in_chan.control_word <= nxt.ctrl;
              in_chan.link_word    <= nxt.link;
            end
          end
          REQ_LIMIT: begin
            if (walk_q.size() == 0) begin
              void'(pending_q.pop_front());
              nwe      = 1'b1;
              cfg_data <= nxt.limit;
              m_limit  = nxt.limit;
            end
          end
          default: begin
            if (walk_q.size() == 0) begin
              void'(pending_q.pop_front());
            end
          end
        endcase
      end
      in_chan.valid <= nv;
      cfg_we        <= nwe;
    end
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("mismatch on result %0d, %s: expected %0h, got %0h",
                 results_seen, name, want, got);
      end
    end
  endtask

  always @(posedge clk) begin : watch_p
    walk_res_t want;
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (walk_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result at address %0h", out_chan.cmd_addr);
          end
        end else begin
          want = walk_q.pop_front();
          check_field("cmd_addr", 32'(want.cmd_addr), 32'(out_chan.cmd_addr));
          check_field("cmd_type", 32'(want.cmd_type), 32'(out_chan.cmd_type));
          check_field("execute", 32'(want.execute), 32'(out_chan.execute));
          check_field("next_addr", 32'(want.next_addr), 32'(out_chan.next_addr));
          check_field("finished", 32'(want.finished), 32'(out_chan.finished));
          check_field("aborted", 32'(want.aborted), 32'(out_chan.aborted));
          check_field("draw_end", 32'(want.draw_end), 32'(out_chan.draw_end));
          check_field("end_status", 32'(want.end_status), 32'(out_chan.end_status));
          check_field("current_op", 32'(want.current_op), 32'(out_chan.current_op));
        end
        results_seen++;
      end
      out_chan.ready <= (results_seen >= CALM_LO && results_seen < CALM_HI) ||
                        $urandom_range(99) >= 24;
    end
  end

  function automatic logic [WORD_W-1:0] make_ctrl(input logic fin, input logic skip,
                                                   input jump_t jump,
                                                   input logic [TYPE_W-1:0] ty);
    return {fin, skip, jump, 8'($urandom), ty};
  endfunction

  task automatic push_item(input logic kind, input logic [WORD_W-1:0] ctrl,
                           input logic [WORD_W-1:0] link);
    req_t r;
    r      = '0;
    r.op   = REQ_CMD;
    r.kind = kind;
    r.ctrl = ctrl;
    r.link = link;
    pending_q.push_back(r);
    stim_count++;
  endtask

  task automatic push_limit(input logic [LIMIT_W-1:0] lim);
    req_t r;
    r       = '0;
    r.op    = REQ_LIMIT;
    r.limit = lim;
    pending_q.push_back(r);
  endtask

  task automatic push_hold();
    req_t r;
    r    = '0;
    r.op = REQ_HOLD;
    pending_q.push_back(r);
  endtask

  task automatic add_walk(input int n);
    logic              fin;
    logic [TYPE_W-1:0] ty;
    push_item(KIND_START, 16'($urandom), 16'($urandom));
    for (int i = 0; i < n; i++) begin
      fin = (i == n - 1) ? ($urandom_range(9) != 0) : ($urandom_range(99) < 2);
      ty  = ($urandom_range(99) < 5) ? TYPE_W'($urandom_range(15, 12))
                                      : TYPE_W'($urandom_range(11, 0));
      push_item(KIND_CMD,
                make_ctrl(fin, $urandom_range(99) < 15, jump_t'($urandom_range(3)), ty),
                16'($urandom));
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_data             = '0;
    in_chan.valid        = 1'b0;
    in_chan.kind         = KIND_START;
    in_chan.control_word = '0;
    in_chan.link_word    = '0;
    out_chan.ready       = 1'b0;
    reqs_sent            = 0;
    results_seen         = 0;
    mismatches           = 0;
    stim_count           = 0;
    m_limit              = LIMIT_RESET;
    m_addr               = '0;
    m_ret                = '0;
    m_ret_ok             = 1'b0;
    m_count              = '0;
    m_status             = '0;
    m_walking            = 1'b0;

    push_item(KIND_CMD, 16'h0000, 16'h0000);
    push_item(KIND_START, 16'h0000, 16'h0000);
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_NEXT, 4'd0), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_ASSIGN, 4'd11), 16'hFFFC);
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_NEXT, 4'd5), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_CALL, 4'd3), 16'h0100);
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_CALL, 4'd7), 16'hFFFF);
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_RETURN, 4'd1), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_RETURN, 4'd2), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b1, JUMP_ASSIGN, 4'd15), 16'h0000);
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_NEXT, 4'd12), 16'($urandom));
    push_item(KIND_CMD, 16'hFFFF, 16'hFFFF);
    push_item(KIND_START, 16'hFFFF, 16'hFFFF);
    push_item(KIND_CMD, 16'hFFFF, 16'hFFFF);
    push_item(KIND_START, 16'($urandom), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b1, JUMP_RETURN, 4'd11), 16'($urandom));
    push_item(KIND_CMD, 16'h8000, 16'h0000);
    push_limit(12'd1);
    push_item(KIND_START, 16'($urandom), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_NEXT, 4'd4), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_NEXT, 4'd6), 16'($urandom));
    push_limit(12'd0);
    push_item(KIND_START, 16'($urandom), 16'($urandom));
    push_item(KIND_CMD, make_ctrl(1'b0, 1'b0, JUMP_NEXT, 4'd9), 16'($urandom));

    for (int phase = 0; stim_count < STIM_TARGET; phase++) begin
      case (phase % 4)
        0: push_limit(12'd4095);
        1: push_limit(LIMIT_W'($urandom_range(8, 1)));
        2: push_limit(LIMIT_RESET);
        default: push_limit(LIMIT_W'($urandom_range(4095, 1)));
      endcase
      for (int w = 0; w < 8; w++) begin
        if ($urandom_range(99) < 82) begin
          add_walk(($urandom_range(9) == 0) ? int'($urandom_range(70, 30))
                                             : int'($urandom_range(20, 1)));
        end else begin
          repeat ($urandom_range(5, 1)) begin
            push_item(1'($urandom), 16'($urandom), 16'($urandom));
          end
        end
        if (w == 4 && phase % 3 == 2) begin
          push_hold();
        end
      end
    end

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() != 0 || in_chan.valid || walk_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && walk_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("FAIL");
    $finish;
  end

endmodule

[command_list_sequencer.f]
design/cls_pkg.sv
design/cls_if.sv
design/cls_step.sv
design/command_list_sequencer.sv
design/cls_checker.sv
bench/tb_command_list_sequencer.sv
